// ===== sv/random_ramp_signal_generator_assert.svh =====
// Assertion macros used by rrsg_checker.
`ifndef RANDOM_RAMP_SIGNAL_GENERATOR_ASSERT_SVH
`define RANDOM_RAMP_SIGNAL_GENERATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define RRSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define RRSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrsg_pkg.sv =====
`timescale 1ns / 1ps
package rrsg_pkg;

    // Widths fixed by the level and count fields
    localparam int LEVEL_BITS = 16;
    localparam int COUNT_BITS = 16;

    // Magnitude of a level difference needs one extra bit
    localparam int DIVIDEND_BITS = LEVEL_BITS + 1;
    localparam int DIV_STEPS     = DIVIDEND_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int PROD_BITS      = 2 * (LEVEL_BITS + 1);
    localparam int FRAC_SHIFT     = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Register reset values
    localparam logic signed [LEVEL_BITS-1:0] RST_MIN_LEVEL   = -16'sd4096;
    localparam logic signed [LEVEL_BITS-1:0] RST_MAX_LEVEL   = 16'sd4096;
    localparam logic [COUNT_BITS-1:0]        RST_MIN_DUR     = 16'd100;
    localparam logic [COUNT_BITS-1:0]        RST_MAX_DUR     = 16'd1000;
    localparam logic [COUNT_BITS-1:0]        RST_CHG_DUR     = 16'd100;
    localparam logic signed [LEVEL_BITS-1:0] RST_START_LEVEL = 16'sd0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_LEVEL   = 3'd0,
        CFG_MAX_LEVEL   = 3'd1,
        CFG_MIN_DUR     = 3'd2,
        CFG_MAX_DUR     = 3'd3,
        CFG_CHG_DUR     = 3'd4,
        CFG_RND_TARGET  = 3'd5,
        CFG_RND_DUR     = 3'd6,
        CFG_START_LEVEL = 3'd7
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_SEG,
        ST_TGT,
        ST_MOVE,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic {
        REQ_ADVANCE = 1'b0,
        REQ_RESTART = 1'b1
    } t_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/random_ramp_signal_generator.sv =====
`timescale 1ns / 1ps
// Random ramp signal generator.
// Input channel (i_in_valid / o_in_stall) carries one request beat: advance
// one tick or restart from the start level, with the random duration offset
// and random target fraction used when a new segment begins. The output
// channel (o_out_valid / i_out_stall) returns exactly one beat per request:
// the level in signed Q3.12 and a flag for a tick that began a segment.
// A restart goes through the check and output states; an advance goes
// through the check state, the segment state and, with a random target, the
// target state when a new segment begins, then the move state, the 17-step
// restoring divider that works out the ramp step while the ramp still
// changes, and the output state. One request is in flight at a time.
// The output register holds a finished beat while the receiver stalls and
// the next request is still accepted; the sequencer waits only if a second
// result is ready before the first has been taken.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data only
// while idle, a rule for the user that the block does not enforce.
// Synchronous reset loads the register defaults, sets the level to the
// default start level and clears the segment; no output is valid.
module random_ramp_signal_generator import rrsg_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [15:0]               i_random_offset,
    input  logic [15:0]               i_random_fraction,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [15:0]        o_level,
    output logic                      o_segment_start
);

    // Configuration registers
    logic signed [LEVEL_BITS-1:0] r_min_level, r_max_level, r_start_level;
    logic [COUNT_BITS-1:0]        r_min_dur, r_max_dur, r_chg_dur;
    logic                         r_rnd_tgt, r_rnd_dur;

    // Sequencer state
    t_state                       r_state, n_state;
    logic                         r_req, n_req;
    logic [15:0]                  r_offset, n_offset;
    logic [15:0]                  r_frac, n_frac;
    logic signed [LEVEL_BITS-1:0] r_cur, n_cur;
    logic signed [LEVEL_BITS-1:0] r_tgt, n_tgt;
    logic [COUNT_BITS-1:0]        r_step, n_step;
    logic [COUNT_BITS-1:0]        r_seglen, n_seglen;
    logic                         r_seg, n_seg;
    logic signed [PROD_BITS-1:0]  r_prod, n_prod;
    logic                         r_neg, n_neg;
    logic                         r_o_valid, n_o_valid;
    logic signed [LEVEL_BITS-1:0] r_o_level, n_o_level;
    logic                         r_o_seg, n_o_seg;

    // Divider handshake
    logic                         div_start;
    logic [DIVIDEND_BITS-1:0]     div_dividend;
    logic [COUNT_BITS-1:0]        div_divisor;
    logic [DIVIDEND_BITS-1:0]     div_quotient;
    t_div_stat                    div_stat;

    // Arithmetic helpers
    logic signed [LEVEL_BITS:0]     span;
    logic signed [PROD_BITS-1:0]    prod;
    logic signed [PROD_BITS-1:0]    prod_adj;
    logic signed [LEVEL_BITS+1:0]   tgt_rnd;
    logic [COUNT_BITS-1:0]          dur_range;
    logic [COUNT_BITS-1:0]          dur_off;
    logic [COUNT_BITS-1:0]          new_len;
    logic signed [LEVEL_BITS-1:0]   clamp_lo;
    logic signed [LEVEL_BITS-1:0]   clamped;
    logic signed [LEVEL_BITS:0]     lvl_diff;
    logic [DIVIDEND_BITS-1:0]       lvl_mag;
    logic signed [LEVEL_BITS+1:0]   q_signed;
    logic signed [LEVEL_BITS+1:0]   lvl_sum;
    logic                           out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level   <= RST_MIN_LEVEL;
            r_max_level   <= RST_MAX_LEVEL;
            r_min_dur     <= RST_MIN_DUR;
            r_max_dur     <= RST_MAX_DUR;
            r_chg_dur     <= RST_CHG_DUR;
            r_rnd_tgt     <= 1'b0;
            r_rnd_dur     <= 1'b0;
            r_start_level <= RST_START_LEVEL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIN_LEVEL:   r_min_level   <= $signed(i_cfg_data[LEVEL_BITS-1:0]);
                CFG_MAX_LEVEL:   r_max_level   <= $signed(i_cfg_data[LEVEL_BITS-1:0]);
                CFG_MIN_DUR:     r_min_dur     <= i_cfg_data[COUNT_BITS-1:0];
                CFG_MAX_DUR:     r_max_dur     <= i_cfg_data[COUNT_BITS-1:0];
                CFG_CHG_DUR:     r_chg_dur     <= i_cfg_data[COUNT_BITS-1:0];
                CFG_RND_TARGET:  r_rnd_tgt     <= i_cfg_data[0];
                CFG_RND_DUR:     r_rnd_dur     <= i_cfg_data[0];
                CFG_START_LEVEL: r_start_level <= $signed(i_cfg_data[LEVEL_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // Random target: min + frac * span / 2^16, rounded toward zero
    assign span     = {r_max_level[LEVEL_BITS-1], r_max_level}
                    - {r_min_level[LEVEL_BITS-1], r_min_level};
    assign prod     = $signed({1'b0, r_frac}) * span;
    assign prod_adj = r_prod[PROD_BITS-1]
                    ? r_prod + PROD_BITS'(signed'((1 << FRAC_SHIFT) - 1))
                    : r_prod;
    assign tgt_rnd  = {{2{r_min_level[LEVEL_BITS-1]}}, r_min_level}
                    + prod_adj[FRAC_SHIFT+LEVEL_BITS+1:FRAC_SHIFT];

    // Segment length, offset saturated below the duration range
    assign dur_range = r_max_dur - r_min_dur;
    assign dur_off   = (r_offset[COUNT_BITS-1:0] >= dur_range)
                     ? dur_range - 1'b1 : r_offset[COUNT_BITS-1:0];
    assign new_len   = (r_rnd_dur && (r_max_dur > r_min_dur))
                     ? r_min_dur + dur_off : r_min_dur;

    // Clamp: upper bound wins when the bounds are swapped
    assign clamp_lo = (r_cur < r_min_level) ? r_min_level : r_cur;
    assign clamped  = (clamp_lo > r_max_level) ? r_max_level : clamp_lo;

    // Ramp step operands and result
    assign lvl_diff = {r_tgt[LEVEL_BITS-1], r_tgt} - {r_cur[LEVEL_BITS-1], r_cur};
    assign lvl_mag  = lvl_diff[LEVEL_BITS] ? DIVIDEND_BITS'(-lvl_diff)
                                           : DIVIDEND_BITS'(lvl_diff);
    assign q_signed = r_neg ? -$signed({1'b0, div_quotient})
                            : $signed({1'b0, div_quotient});
    assign lvl_sum  = {{2{r_cur[LEVEL_BITS-1]}}, r_cur} + q_signed;

    assign div_dividend = lvl_mag;
    assign div_divisor  = r_chg_dur - r_step;
    assign out_free     = !r_o_valid || !i_out_stall;

    // Next state and datapath updates
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_offset  = r_offset;
        n_frac    = r_frac;
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_step    = r_step;
        n_seglen  = r_seglen;
        n_seg     = r_seg;
        n_prod    = r_prod;
        n_neg     = r_neg;
        n_o_level = r_o_level;
        n_o_seg   = r_o_seg;
        n_o_valid = r_o_valid && i_out_stall;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_req_type;
                    n_offset = i_random_offset;
                    n_frac   = i_random_fraction;
                    n_state  = ST_CHK;
                end
            end
            ST_CHK: begin
                n_seg = 1'b0;
                if (t_req'(r_req) == REQ_RESTART) begin
                    n_cur    = r_start_level;
                    n_tgt    = '0;
                    n_step   = '0;
                    n_seglen = '0;
                    n_state  = ST_OUT;
                end else if (r_step >= r_seglen) begin
                    n_state = ST_SEG;
                end else begin
                    n_state = ST_MOVE;
                end
            end
            ST_SEG: begin
                // Open a segment: alternate target uses the level before clamp
                n_seglen = new_len;
                n_prod   = prod;
                n_tgt    = (r_cur >= r_max_level) ? r_min_level : r_max_level;
                n_cur    = clamped;
                n_step   = '0;
                n_seg    = 1'b1;
                n_state  = r_rnd_tgt ? ST_TGT : ST_MOVE;
            end
            ST_TGT: begin
                n_tgt   = tgt_rnd[LEVEL_BITS-1:0];
                n_state = ST_MOVE;
            end
            ST_MOVE: begin
                if (r_chg_dur <= r_step) begin
                    n_cur   = r_tgt;
                    n_state = ST_OUT;
                end else begin
                    div_start = 1'b1;
                    n_neg     = lvl_diff[LEVEL_BITS];
                    n_state   = ST_DIV;
                end
                if (r_step != COUNT_MAX) begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_cur   = lvl_sum[LEVEL_BITS-1:0];
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hand over once the output register is free
                if (out_free) begin
                    n_o_level = r_cur;
                    n_o_seg   = r_seg;
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and level state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_cur     <= RST_START_LEVEL;
            r_tgt     <= '0;
            r_step    <= '0;
            r_seglen  <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cur     <= n_cur;
            r_tgt     <= n_tgt;
            r_step    <= n_step;
            r_seglen  <= n_seglen;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_offset  <= n_offset;
        r_frac    <= n_frac;
        r_seg     <= n_seg;
        r_prod    <= n_prod;
        r_neg     <= n_neg;
        r_o_level <= n_o_level;
        r_o_seg   <= n_o_seg;
    end

    rrsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_stat     (div_stat)
    );

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_level         = r_o_level;
    assign o_segment_start = r_o_seg;

endmodule

// ===== sv/rrsg_div.sv =====
`timescale 1ns / 1ps
module rrsg_div import rrsg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [COUNT_BITS-1:0]    i_divisor,
    output logic [DIVIDEND_BITS-1:0] o_quotient,
    output t_div_stat                o_stat
);

    logic                     r_busy;
    logic                     r_done;
    logic [DIV_CNT_BITS-1:0]  r_cnt;
    logic [COUNT_BITS-1:0]    r_rem;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [COUNT_BITS-1:0]    r_dvs;

    logic [COUNT_BITS:0]      trial;
    logic                     fits;
    logic [COUNT_BITS:0]      diff;

    // Shift in one dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[DIVIDEND_BITS-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and combined dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== sv/rrsg_checker.sv =====
`timescale 1ns / 1ps
`include "random_ramp_signal_generator_assert.svh"
module rrsg_checker import rrsg_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      i_req_type,
    input logic [15:0]               i_random_offset,
    input logic [15:0]               i_random_fraction,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [15:0]        o_level,
    input logic                      o_segment_start
);

    // Leave reset idle, ready and with nothing to deliver
    `RRSG_ASSERT_IMPLY(a_reset_clean, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid && !o_in_stall, "not idle after reset")

    // An accepted request keeps the sequencer busy, so no request follows back to back
    `RRSG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall ##1 o_in_stall, "request accepted back to back")

    // A stalled result beat holds
    `RRSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_level) && $stable(o_segment_start), "stalled result changed")

    // A new result never appears while the sequencer is still free
    `RRSG_ASSERT_IMPLY(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without a request")

endmodule

bind random_ramp_signal_generator rrsg_checker u_rrsg_checker (.*);

// ===== tb/random_ramp_signal_generator_checker.sv =====
`timescale 1ns / 1ps
module random_ramp_signal_generator_checker import rrsg_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_req_type,
    input  logic [15:0]               i_random_offset,
    input  logic [15:0]               i_random_fraction,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [15:0]        i_level,
    input  logic                      i_segment_start,
    output int                        o_mismatches,
    output int                        o_pending
);

    typedef struct packed {
        logic signed [15:0] level;
        logic               seg_start;
    } t_tick;

    localparam int LVL_HI = 2 ** (LEVEL_BITS - 1) - 1;
    localparam int LVL_LO = -LVL_HI - 1;

    // Shadow registers
    int          min_lvl;
    int          max_lvl;
    int          start_lvl;
    int unsigned min_dur;
    int unsigned max_dur;
    int unsigned chg_dur;
    bit          rnd_tgt;
    bit          rnd_dur;

    // Ramp state
    int          cur_lvl;
    int          tgt_lvl;
    int unsigned step_cnt;
    int unsigned seg_len;

    t_tick level_queue[$];
    int    mismatches = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic int clip_level(longint v);
        if (v > LVL_HI) begin
            return LVL_HI;
        end
        if (v < LVL_LO) begin
            return LVL_LO;
        end
        return int'(v);
    endfunction

    task automatic load_defaults();
        min_lvl   = int'(RST_MIN_LEVEL);
        max_lvl   = int'(RST_MAX_LEVEL);
        min_dur   = RST_MIN_DUR;
        max_dur   = RST_MAX_DUR;
        chg_dur   = RST_CHG_DUR;
        rnd_tgt   = 1'b0;
        rnd_dur   = 1'b0;
        start_lvl = int'(RST_START_LEVEL);
        cur_lvl   = start_lvl;
        tgt_lvl   = 0;
        step_cnt  = 0;
        seg_len   = 0;
    endtask

    task automatic set_register(t_cfg_index idx, logic [15:0] val);
        case (idx)
            CFG_MIN_LEVEL: begin
                min_lvl = int'($signed(val));
            end
            CFG_MAX_LEVEL: begin
                max_lvl = int'($signed(val));
            end
            CFG_MIN_DUR: begin
                min_dur = val;
            end
            CFG_MAX_DUR: begin
                max_dur = val;
            end
            CFG_CHG_DUR: begin
                chg_dur = val;
            end
            CFG_RND_TARGET: begin
                rnd_tgt = val[0];
            end
            CFG_RND_DUR: begin
                rnd_dur = val[0];
            end
            CFG_START_LEVEL: begin
                start_lvl = int'($signed(val));
            end
            default: begin
            end
        endcase
    endtask

    // Advance or restart the ramp by one beat and return the level it should show
    task automatic step_ramp(input logic req, input logic [15:0] offset,
                             input logic [15:0] frac, output t_tick res);
        int unsigned spread;
        int unsigned off;
        longint      prod;
        int          clamped;
        res.seg_start = 1'b0;
        if (req == REQ_RESTART) begin
            cur_lvl  = clip_level(start_lvl);
            tgt_lvl  = 0;
            step_cnt = 0;
            seg_len  = 0;
        end else begin
            if (step_cnt >= seg_len) begin
                // Pick the new segment length
                seg_len = min_dur;
                if (rnd_dur && max_dur > min_dur) begin
                    spread = max_dur - min_dur;
                    off    = offset;
                    if (off >= spread) begin
                        off = spread - 1;
                    end
                    seg_len = min_dur + off;
                end
                // Pick the new target: random point in the span, or flip bounds
                if (rnd_tgt) begin
                    prod    = longint'(frac) * longint'(max_lvl - min_lvl);
                    tgt_lvl = clip_level(longint'(min_lvl) + prod / 64'sd65536);
                end else if (cur_lvl >= max_lvl) begin
                    tgt_lvl = clip_level(min_lvl);
                end else begin
                    tgt_lvl = clip_level(max_lvl);
                end
                step_cnt = 0;
                // Clamp lower bound first so swapped bounds end on max
                clamped = cur_lvl;
                if (clamped < min_lvl) begin
                    clamped = min_lvl;
                end
                if (clamped > max_lvl) begin
                    clamped = max_lvl;
                end
                cur_lvl       = clip_level(clamped);
                res.seg_start = 1'b1;
            end
            if (chg_dur <= step_cnt) begin
                cur_lvl = tgt_lvl;
            end else begin
                cur_lvl = clip_level(longint'(cur_lvl) +
                                     (tgt_lvl - cur_lvl) / int'(chg_dur - step_cnt));
            end
            if (step_cnt < int'(COUNT_MAX)) begin
                step_cnt++;
            end
        end
        res.level = cur_lvl[15:0];
    endtask

    task automatic report_fault(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Track config writes, predict on each request beat, compare each result beat
    always @(posedge i_clk) begin : watch
        t_tick want;
        t_tick got;
        if (!i_rst_n) begin
            load_defaults();
            level_queue.delete();
        end else begin
            if (i_cfg_we) begin
                set_register(t_cfg_index'(i_cfg_index), i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                step_ramp(i_req_type, i_random_offset, i_random_fraction, want);
                level_queue.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got.level     = i_level;
                got.seg_start = i_segment_start;
                if (level_queue.size() == 0) begin
                    report_fault($sformatf("unexpected result beat: level %0d start %0b",
                                           got.level, got.seg_start));
                end else begin
                    want = level_queue.pop_front();
                    if (got.level !== want.level || got.seg_start !== want.seg_start) begin
                        report_fault($sformatf(
                            "result mismatch: level exp %0d got %0d, start exp %0b got %0b",
                            want.level, got.level, want.seg_start, got.seg_start));
                    end
                end
            end
        end
        o_pending    <= level_queue.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== tb/tb_random_ramp_signal_generator.sv =====
`timescale 1ns / 1ps
module tb_random_ramp_signal_generator;
    import rrsg_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_req_type;
    logic [15:0]               i_random_offset;
    logic [15:0]               i_random_fraction;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [15:0]        o_level;
    logic                      o_segment_start;

    int mismatches;
    int pending;
    bit idle_on = 1'b1;

    logic [15:0] s_mn, s_mx, s_mnd, s_mxd, s_chg, s_start;
    int          ph, n, lo_i, hi_i;

    random_ramp_signal_generator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_random_offset   (i_random_offset),
        .i_random_fraction (i_random_fraction),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_level           (o_level),
        .o_segment_start   (o_segment_start)
    );

    random_ramp_signal_generator_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_random_offset   (i_random_offset),
        .i_random_fraction (i_random_fraction),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_level           (o_level),
        .i_segment_start   (o_segment_start),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side now and then
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= idle_on && ($urandom_range(0, 99) < 15);
        end
    end

    // Bound the run
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Drop valid and hold until every predicted level has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Write every register once the block has gone quiet
    task automatic program_settings(logic [15:0] mn, logic [15:0] mx, logic [15:0] mnd,
                                    logic [15:0] mxd, logic [15:0] chg, logic rt,
                                    logic rd, logic [15:0] start);
        wait_drained();
        write_reg(CFG_MIN_LEVEL, mn);
        write_reg(CFG_MAX_LEVEL, mx);
        write_reg(CFG_MIN_DUR, mnd);
        write_reg(CFG_MAX_DUR, mxd);
        write_reg(CFG_CHG_DUR, chg);
        write_reg(CFG_RND_TARGET, {15'($urandom), rt});
        write_reg(CFG_RND_DUR, {15'($urandom), rd});
        write_reg(CFG_START_LEVEL, start);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one request beat, with an occasional gap in front of it
    task automatic send_tick(t_req req, logic [15:0] offset, logic [15:0] frac);
        if (idle_on && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_req_type        <= req;
        i_random_offset   <= offset;
        i_random_fraction <= frac;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_MIN_LEVEL;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_req_type        <= REQ_ADVANCE;
        i_random_offset   <= '0;
        i_random_fraction <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: a restart, then an advance that opens a segment and ramps towards max
        send_tick(REQ_RESTART, 16'd0, 16'd0);
        send_tick(REQ_ADVANCE, 16'd0, 16'd0);
        send_tick(REQ_ADVANCE, 16'hFFFF, 16'hFFFF);
        send_tick(REQ_ADVANCE, 16'($urandom), 16'($urandom));
        send_tick(REQ_ADVANCE, 16'($urandom), 16'($urandom));
        send_tick(REQ_RESTART, 16'hFFFF, 16'hFFFF);
        send_tick(REQ_ADVANCE, 16'd5, 16'h8000);
        send_tick(REQ_ADVANCE, 16'd1, 16'd1);

        // Full level range, random target and length, offset past the limit
        program_settings(16'h8000, 16'h7FFF, 16'd2, 16'd5, 16'd3, 1'b1, 1'b1, 16'h7FFF);
        send_tick(REQ_RESTART, 16'd0, 16'd0);
        send_tick(REQ_ADVANCE, 16'hFFFF, 16'hFFFF);
        send_tick(REQ_ADVANCE, 16'd3, 16'd0);
        send_tick(REQ_ADVANCE, 16'd0, 16'h8000);
        send_tick(REQ_ADVANCE, 16'd2, 16'hFFFF);
        send_tick(REQ_ADVANCE, 16'd9, 16'd1);
        send_tick(REQ_ADVANCE, 16'd1, 16'h4000);
        send_tick(REQ_ADVANCE, 16'd0, 16'hC000);

        // Swapped bounds, zero lengths, zero change time, offset ignored
        program_settings(16'd4096, 16'hF000, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'h8000);
        send_tick(REQ_RESTART, 16'd0, 16'd0);
        send_tick(REQ_ADVANCE, 16'hFFFF, 16'd0);
        send_tick(REQ_ADVANCE, 16'd0, 16'd0);
        send_tick(REQ_ADVANCE, 16'd7, 16'd0);

        // Extreme swapped bounds with random target: negative span
        program_settings(16'h7FFF, 16'h8000, 16'd1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h8000);
        send_tick(REQ_RESTART, 16'd0, 16'd0);
        send_tick(REQ_ADVANCE, 16'hFFFF, 16'hFFFF);
        send_tick(REQ_ADVANCE, 16'd0, 16'd1);
        send_tick(REQ_ADVANCE, 16'd0, 16'h8001);
        send_tick(REQ_ADVANCE, 16'd0, 16'h7FFF);

        // Random settings, mostly short segments so new targets come often
        for (ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 9))
                0: begin
                    s_mn = 16'h8000;
                    s_mx = 16'h7FFF;
                end
                1: begin
                    s_mn = 16'($urandom);
                    s_mx = 16'($urandom);
                end
                default: begin
                    lo_i = -int'($urandom_range(0, 12000));
                    hi_i = int'($urandom_range(0, 12000));
                    s_mn = lo_i[15:0];
                    s_mx = hi_i[15:0];
                end
            endcase
            s_mnd = 16'($urandom_range(0, 8));
            case ($urandom_range(0, 9))
                6: s_mxd = 16'hFFFF;
                7: s_mxd = s_mnd;
                8: s_mxd = 16'($urandom_range(0, s_mnd));
                9: s_mxd = s_mnd + 16'($urandom_range(1, 6));
                default: s_mxd = s_mnd + 16'($urandom_range(0, 20));
            endcase
            case ($urandom_range(0, 9))
                0: s_chg = 16'd0;
                1: s_chg = 16'hFFFF;
                default: s_chg = 16'($urandom_range(1, 24));
            endcase
            s_start = 16'($urandom);
            program_settings(s_mn, s_mx, s_mnd, s_mxd, s_chg, 1'($urandom), 1'($urandom),
                             s_start);
            idle_on = (ph != 5);
            for (n = 0; n < 60; n++) begin
                // Once, hold off the sender until the block has caught up
                if (ph == 3 && n == 30) begin
                    wait_drained();
                end
                send_tick(($urandom_range(0, 99) < 6) ? REQ_RESTART : REQ_ADVANCE,
                          $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom),
                          16'($urandom));
            end
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
